// File: rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and constants shared by the positional list store and its cells.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
    } t_rsp;

    // Per-beat command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

// File: rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One slot of the list: holds a word, takes its left neighbour's word on an
// insert below it and its right neighbour's word on a delete at or below it.
// ----------------------------------------------------------------------------
module pls_cell #(
    parameter int IW       = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                       i_clk,
    input  pls_pkg::t_cell_ctrl        i_ctrl,
    input  logic [IW-1:0]              i_pos,
    input  logic [pls_pkg::WORD_W-1:0] i_value,
    input  logic [pls_pkg::WORD_W-1:0] i_left,
    input  logic [pls_pkg::WORD_W-1:0] i_right,
    output logic [pls_pkg::WORD_W-1:0] o_word,
    output logic [pls_pkg::WORD_W-1:0] o_tap
);
    import pls_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (MY_IDX == i_pos) begin
                n_word = i_value;
            end else if (MY_IDX > i_pos) begin
                n_word = i_left;
            end
        end else if (i_ctrl.del) begin
            if (MY_IDX >= i_pos) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = (MY_IDX == i_pos) ? r_word : '0;

endmodule

// File: rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of words held in a chain of shifting slot cells.
// ----------------------------------------------------------------------------
// The result strobe is registered and rises in the cycle after the request beat.
// Throughput: one request per cycle; the whole slot chain shifts at once,
// so busy never rises and the result register is the only stage.
// Reset clears the entry count and sets the capacity limit to 16; slot words
// keep whatever they held and are only read once written.
module positional_list_store #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pls_pkg::t_req             i_req,
    output logic                      o_res_strobe,
    output pls_pkg::t_rsp             o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pls_pkg::CAP_W-1:0] i_cfg_data
);
    import pls_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

    logic [CAP_W-1:0]  r_cap;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_res_valid;
    t_rsp              r_result;
    t_rsp              n_result;

    logic              accept;
    logic [CMPW-1:0]   count_x;
    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cap_x;
    logic [CMPW-1:0]   eff_cap;
    logic [CMPW-1:0]   ins_pos;
    logic [IW-1:0]     cell_pos;
    logic              full;
    logic              in_range;
    t_cell_ctrl        ctrl;
    logic [WORD_W-1:0] rd_word;

    logic [WORD_W-1:0] words [DEPTH];
    logic [WORD_W-1:0] taps  [DEPTH];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign count_x  = CMPW'(r_count);
    assign pos_x    = CMPW'(i_req.pos);
    assign cap_x    = CMPW'(r_cap);
    assign eff_cap  = (cap_x > DEPTH_C) ? DEPTH_C : cap_x;
    assign full     = (count_x >= eff_cap);
    assign in_range = (pos_x < count_x);
    // An insert beyond the end appends.
    assign ins_pos  = (pos_x > count_x) ? count_x : pos_x;

    always_comb begin
        ctrl     = '0;
        cell_pos = IW'(pos_x);
        n_count  = r_count;
        n_result = '0;
        case (t_op'(i_req.op))
            OP_INSERT: begin
                cell_pos = IW'(ins_pos);
                if (full) begin
                    n_result.status = ST_FULL;
                end else begin
                    ctrl.ins        = accept;
                    n_count         = r_count + CW'(1);
                    n_result.status = ST_DONE;
                end
            end
            OP_GET, OP_DELETE: begin
                if (!in_range) begin
                    n_result.status = ST_RANGE;
                end else begin
                    n_result.status     = ST_DONE;
                    n_result.read_value = rd_word;
                    if (t_op'(i_req.op) == OP_DELETE) begin
                        ctrl.del = accept;
                        n_count  = r_count - CW'(1);
                    end
                end
            end
            OP_CLEAR: begin
                n_count         = '0;
                n_result.status = ST_DONE;
            end
            default: begin
                n_result.status = ST_DONE;
            end
        endcase
        n_result.count = COUNT_W'(n_count);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = words[g];
        end else begin : g_mid_r
            assign right_w = words[g+1];
        end
        pls_cell #(
            .IW       (IW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_pos   (cell_pos),
            .i_value (i_req.value),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (words[g]),
            .o_tap   (taps[g])
        );
    end

    // Only the addressed cell drives a non-zero tap.
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_word = rd_word | taps[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            r_res_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_res_strobe = r_res_valid;
    assign o_result     = r_result;

endmodule

// File: rtl/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks on the positional list store's request and result beats.
// ----------------------------------------------------------------------------
module pls_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_res_strobe,
    input pls_pkg::t_rsp o_result
);
    import pls_pkg::*;

    // Every request beat yields exactly one result beat, in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_res_strobe)
        else $error("request beat without a result beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_res_strobe)
        else $error("result beat without a request beat");

    // A failed request returns no word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_result.status == ST_FULL || o_result.status == ST_RANGE))
        |-> (o_result.read_value == '0))
        else $error("failed request returned a word");

    // A full insert leaves the count as the previous result reported it.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && $past(o_res_strobe) && o_result.status == ST_FULL)
        |-> (o_result.count == $past(o_result.count)))
        else $error("count changed on a full insert");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list store. A scoreboard class holds
// its own copy of the slot list and the capacity limit. It works out the
// result of every accepted request and compares each strobed result with the
// oldest one still waiting. A short directed pass is followed by random
// phases, each under a capacity limit written just before it, with random
// gaps between requests.
// ----------------------------------------------------------------------------
module tb;
    import pls_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int ITEMS_PER_PHASE = 100;

    class list_scoreboard;
        logic [WORD_W-1:0] slots [DEPTH_DEF];
        int unsigned entries;
        logic [CAP_W-1:0] capacity;
        t_rsp expected_q [$];
        int unsigned errors;

        function new();
            entries = 0;
            capacity = CAP_RESET;
            errors = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int unsigned limit;
            int unsigned at;
            int unsigned i;
            limit = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
            rsp = '0;
            case (t_op'(req.op))
                OP_INSERT: begin
                    // The full check wins over any look at the position.
                    if (entries >= limit) begin
                        rsp.status = ST_FULL;
                    end else begin
                        at = (req.pos > entries) ? entries : req.pos;
                        for (i = entries; i > at; i--)
                            slots[i] = slots[i-1];
                        slots[at] = req.value;
                        entries++;
                    end
                end
                OP_GET, OP_DELETE: begin
                    if (req.pos >= entries) begin
                        rsp.status = ST_RANGE;
                    end else begin
                        rsp.read_value = slots[req.pos];
                        if (t_op'(req.op) == OP_DELETE) begin
                            for (i = req.pos + 1; i < entries; i++)
                                slots[i-1] = slots[i];
                            entries--;
                        end
                    end
                end
                default: begin
                    entries = 0;
                end
            endcase
            if (rsp.status != ST_DONE)
                rsp.read_value = '0;
            rsp.count = entries[COUNT_W-1:0];
            expected_q.push_back(rsp);
        endfunction

        function void report(string what, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, exp, act);
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status)
                report("status", WORD_W'(exp.status), WORD_W'(got.status));
            if (got.read_value !== exp.read_value)
                report("read_value", exp.read_value, got.read_value);
            if (got.count !== exp.count)
                report("count", WORD_W'(exp.count), WORD_W'(got.count));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_res_strobe;
    t_rsp o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data = '0;

    list_scoreboard sb;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 0;

    positional_list_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe)
            sb.check_result(o_result);
    end

    // Counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            burst_left = $urandom_range(5, 30);
        return $urandom_range(0, 13);
    endfunction

    // Entered and left on a falling edge; start stays high when the next
    // request follows without a gap.
    task automatic drive_request(t_op op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] value);
        t_req req;
        int unsigned gap;
        req.op = op;
        req.pos = pos;
        req.value = value;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_capacity(cap);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly positions near the live range so that gets and deletes succeed,
    // with some anywhere in the field.
    task automatic drive_random(int unsigned ins_pct);
        int unsigned r;
        t_op op;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] value;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = OP_CLEAR;
        else if (r < 3 + ins_pct)
            op = OP_INSERT;
        else if (r < 3 + ins_pct + (97 - ins_pct) / 2)
            op = OP_GET;
        else
            op = OP_DELETE;
        if ($urandom_range(0, 9) < 8)
            pos = POS_W'($urandom_range(0, sb.entries));
        else
            pos = POS_W'($urandom_range(0, 31));
        case ($urandom_range(0, 15))
            0: value = '0;
            1: value = '1;
            default: value = $urandom;
        endcase
        drive_request(op, pos, value);
    endtask

    initial begin
        logic [CAP_W-1:0] caps [9];
        sb = new();
        caps = '{5'd31, 5'd16, 5'd17, 5'd1, 5'd0, 5'd5, 5'd16, 5'd15, 5'd31};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at the reset capacity.
        drive_request(OP_GET, 5'd0, 32'h0);
        drive_request(OP_DELETE, 5'd0, 32'h0);
        drive_request(OP_INSERT, 5'd31, 32'hFFFF_FFFF);
        drive_request(OP_INSERT, 5'd0, 32'h0000_0000);
        drive_request(OP_INSERT, 5'd1, 32'h5A5A_A5A5);
        drive_request(OP_GET, 5'd0, 32'hFFFF_FFFF);
        drive_request(OP_GET, 5'd2, 32'h0);
        drive_request(OP_GET, 5'd3, 32'h0);
        drive_request(OP_GET, 5'd31, 32'h0);
        drive_request(OP_DELETE, 5'd1, 32'h0);
        drive_request(OP_DELETE, 5'd5, 32'h0);
        drive_request(OP_INSERT, 5'd20, 32'h8000_0001);
        drive_request(OP_CLEAR, 5'd31, 32'hFFFF_FFFF);
        drive_request(OP_GET, 5'd0, 32'h0);

        // Zero capacity refuses every insert.
        write_capacity(5'd0);
        drive_request(OP_INSERT, 5'd0, 32'h1234_5678);
        drive_request(OP_INSERT, 5'd31, 32'hFFFF_FFFF);

        // A small capacity fills up; the full case must win over a bad position.
        write_capacity(5'd2);
        drive_request(OP_INSERT, 5'd0, 32'hDEAD_BEEF);
        drive_request(OP_INSERT, 5'd0, 32'hCAFE_F00D);
        drive_request(OP_INSERT, 5'd31, 32'h0BAD_0BAD);
        drive_request(OP_DELETE, 5'd1, 32'h0);
        drive_request(OP_DELETE, 5'd0, 32'h0);
        drive_request(OP_CLEAR, 5'd0, 32'h0);

        foreach (caps[k]) begin
            int unsigned ins_pct;
            write_capacity(caps[k]);
            ins_pct = $urandom_range(30, 70);
            repeat (ITEMS_PER_PHASE)
                drive_random(ins_pct);
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/positional_list_store.sv
rtl/pls_checker.sv
tb/sv/tb.sv
